@@ rtl/core/fr_pkg.sv @@
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types, step addresses and microcode ROM of the fraction reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package fr_pkg;

  // default operand width
  localparam int DATA_WIDTH_DEF = 32;

  // microprogram counter
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // step addresses
  localparam upc_t STEP_IDLE   = 4'd0;
  localparam upc_t STEP_CHKN   = 4'd1;
  localparam upc_t STEP_CHKD   = 4'd2;
  localparam upc_t STEP_STRIP2 = 4'd3;
  localparam upc_t STEP_STRIPA = 4'd4;
  localparam upc_t STEP_STRIPB = 4'd5;
  localparam upc_t STEP_SUB    = 4'd6;
  localparam upc_t STEP_MKG    = 4'd7;
  localparam upc_t STEP_DIV    = 4'd8;
  localparam upc_t STEP_OUT    = 4'd9;
  localparam upc_t STEP_FIN    = 4'd10;
  localparam upc_t STEP_ZERO   = 4'd11;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SHBOTH,
    OP_SHA,
    OP_SHB,
    OP_SUB,
    OP_MKG,
    OP_DIV,
    OP_OUT,
    OP_ZERO
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_NM_ZERO,
    C_B_ZERO,
    C_BOTH_EVEN,
    C_A_EVEN,
    C_B_EVEN,
    C_AB_NE,
    C_CNT_RUN,
    C_OUT_BUSY
  } cond_t;

  // when the step's operation is carried out
  typedef enum logic [1:0] {
    G_ALL,
    G_TAKEN,
    G_NOT_TAKEN
  } gate_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    gate_t gate;
    upc_t  tgt;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic nm_zero;
    logic b_zero;
    logic both_even;
    logic a_even;
    logic b_even;
    logic ab_ne;
    logic cnt_run;
    logic out_busy;
  } stat_t;

  // microcode ROM: jump to tgt when cond holds, else fall through
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    unique case (addr)
      STEP_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_IN,     gate: G_NOT_TAKEN, tgt: STEP_IDLE};
      STEP_CHKN:   w = '{op: OP_NOP,    cond: C_NM_ZERO,   gate: G_ALL,       tgt: STEP_ZERO};
      STEP_CHKD:   w = '{op: OP_NOP,    cond: C_B_ZERO,    gate: G_ALL,       tgt: STEP_MKG};
      STEP_STRIP2: w = '{op: OP_SHBOTH, cond: C_BOTH_EVEN, gate: G_TAKEN,     tgt: STEP_STRIP2};
      STEP_STRIPA: w = '{op: OP_SHA,    cond: C_A_EVEN,    gate: G_TAKEN,     tgt: STEP_STRIPA};
      STEP_STRIPB: w = '{op: OP_SHB,    cond: C_B_EVEN,    gate: G_TAKEN,     tgt: STEP_STRIPB};
      STEP_SUB:    w = '{op: OP_SUB,    cond: C_AB_NE,     gate: G_ALL,       tgt: STEP_STRIPB};
      STEP_MKG:    w = '{op: OP_MKG,    cond: C_NEVER,     gate: G_ALL,       tgt: STEP_IDLE};
      STEP_DIV:    w = '{op: OP_DIV,    cond: C_CNT_RUN,   gate: G_ALL,       tgt: STEP_DIV};
      STEP_OUT:    w = '{op: OP_OUT,    cond: C_OUT_BUSY,  gate: G_NOT_TAKEN, tgt: STEP_OUT};
      STEP_FIN:    w = '{op: OP_NOP,    cond: C_ALWAYS,    gate: G_ALL,       tgt: STEP_IDLE};
      STEP_ZERO:   w = '{op: OP_ZERO,   cond: C_ALWAYS,    gate: G_ALL,       tgt: STEP_OUT};
      default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    gate: G_ALL,       tgt: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fr_useq.sv @@
// ----------------------------------------------------------------------------
// fr_useq
// Microprogram sequencer: step counter, ROM fetch and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module fr_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire fr_pkg::stat_t stat_i,
  output      logic          in_stall,
  output      fr_pkg::ctrl_t ctrl_o
);

  fr_pkg::upc_t   upc_r;
  fr_pkg::upc_t   upc_nxt;
  fr_pkg::uword_t uw;
  logic           hit;
  logic           exec;

  // fetch
  assign uw = fr_pkg::ucode(upc_r);

  // condition select
  always_comb begin
    case (uw.cond)
      fr_pkg::C_NEVER:     hit = 1'b0;
      fr_pkg::C_ALWAYS:    hit = 1'b1;
      fr_pkg::C_NO_IN:     hit = !in_valid;
      fr_pkg::C_NM_ZERO:   hit = stat_i.nm_zero;
      fr_pkg::C_B_ZERO:    hit = stat_i.b_zero;
      fr_pkg::C_BOTH_EVEN: hit = stat_i.both_even;
      fr_pkg::C_A_EVEN:    hit = stat_i.a_even;
      fr_pkg::C_B_EVEN:    hit = stat_i.b_even;
      fr_pkg::C_AB_NE:     hit = stat_i.ab_ne;
      fr_pkg::C_CNT_RUN:   hit = stat_i.cnt_run;
      fr_pkg::C_OUT_BUSY:  hit = stat_i.out_busy;
      default:             hit = 1'b0;
    endcase
  end

  // operation gating
  always_comb begin
    case (uw.gate)
      fr_pkg::G_ALL:       exec = 1'b1;
      fr_pkg::G_TAKEN:     exec = hit;
      fr_pkg::G_NOT_TAKEN: exec = !hit;
      default:             exec = 1'b0;
    endcase
  end

  assign ctrl_o.op = exec ? uw.op : fr_pkg::OP_NOP;
  assign upc_nxt   = hit ? uw.tgt : fr_pkg::upc_t'(upc_r + 1'b1);

  // a word is taken only at the idle step, and never while in reset
  assign in_stall = !rst_n || (upc_r != fr_pkg::STEP_IDLE);

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= fr_pkg::STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fr_dpath.sv @@
// ----------------------------------------------------------------------------
// fr_dpath
// Datapath: magnitudes, binary GCD registers, shared-divisor restoring
// division and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fr_dpath #(
  parameter int DATA_WIDTH = fr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fr_pkg::ctrl_t           ctrl_i,
  input  wire logic [DATA_WIDTH-1:0]   numer_in,
  input  wire logic [DATA_WIDTH-1:0]   denom_in,
  input  wire logic                    out_stall,
  output      fr_pkg::stat_t           stat_o,
  output      logic                    out_valid,
  output      logic [DATA_WIDTH-1:0]   numer_out,
  output      logic [DATA_WIDTH-2:0]   denom_out
);

  localparam int W  = DATA_WIDTH;
  localparam int KW = $clog2(W);
  localparam logic [W-1:0] ONE_W = W'(1);
  localparam logic [W-1:0] LIMIT = {1'b0, {(W-1){1'b1}}};

  // operand and working registers
  logic [W-1:0]  nm_r;
  logic [W-1:0]  dm_r;
  logic          n_neg_r;
  logic          d_neg_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [KW-1:0] k_r;
  logic [W-1:0]  g_r;
  logic [W-1:0]  qn_r;
  logic [W-1:0]  qd_r;
  logic [W-1:0]  rmn_r;
  logic [W-1:0]  rmd_r;
  logic [KW-1:0] cnt_r;
  logic          out_valid_r;
  logic [W-1:0]  out_numer_r;
  logic [W-2:0]  out_denom_r;

  logic [W-1:0]   numer_abs;
  logic [W-1:0]   denom_abs;
  logic           a_gt_b;
  logic [W-1:0]   diff;
  logic [2*W-1:0] dstep_n;
  logic [2*W-1:0] dstep_d;
  logic [W-1:0]   sat_n;
  logic           res_neg;

  // one restoring division step: returns {remainder, quotient}
  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                              input logic [W-1:0] q,
                                              input logic [W-1:0] d);
    logic [W:0] sh;
    logic [W:0] trial;
    sh    = {rem, q[W-1]};
    trial = sh - {1'b0, d};
    if (!trial[W]) begin
      div_step = {trial[W-1:0], q[W-2:0], 1'b1};
    end else begin
      div_step = {sh[W-1:0], q[W-2:0], 1'b0};
    end
  endfunction

  // magnitudes of the incoming word
  assign numer_abs = numer_in[W-1] ? (~numer_in + ONE_W) : numer_in;
  assign denom_abs = denom_in[W-1] ? (~denom_in + ONE_W) : denom_in;

  // GCD subtract: smaller stays, halved difference replaces the other
  assign a_gt_b = (a_r > b_r);
  assign diff   = a_gt_b ? (a_r - b_r) : (b_r - a_r);

  // both quotients against the same divisor
  assign dstep_n = div_step(rmn_r, qn_r, g_r);
  assign dstep_d = div_step(rmd_r, qd_r, g_r);

  // saturation and sign
  assign sat_n   = qn_r[W-1] ? LIMIT : qn_r;
  assign res_neg = (dm_r == '0) ? n_neg_r : (n_neg_r ^ d_neg_r);

  // status back to the sequencer
  assign stat_o.nm_zero   = (nm_r == '0);
  assign stat_o.b_zero    = (b_r == '0);
  assign stat_o.both_even = !a_r[0] && !b_r[0];
  assign stat_o.a_even    = !a_r[0];
  assign stat_o.b_even    = !b_r[0];
  assign stat_o.ab_ne     = (a_r != b_r);
  assign stat_o.cnt_run   = (cnt_r != KW'(W-1));
  assign stat_o.out_busy  = out_valid_r && out_stall;

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl_i.op)
      fr_pkg::OP_LOAD: begin
        nm_r    <= numer_abs;
        dm_r    <= denom_abs;
        n_neg_r <= numer_in[W-1];
        d_neg_r <= denom_in[W-1];
        a_r     <= numer_abs;
        b_r     <= denom_abs;
        k_r     <= '0;
      end
      fr_pkg::OP_SHBOTH: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end
      fr_pkg::OP_SHA: begin
        a_r <= a_r >> 1;
      end
      fr_pkg::OP_SHB: begin
        b_r <= b_r >> 1;
      end
      fr_pkg::OP_SUB: begin
        a_r <= a_gt_b ? b_r : a_r;
        b_r <= diff >> 1;
      end
      fr_pkg::OP_MKG: begin
        g_r   <= a_r << k_r;
        qn_r  <= nm_r;
        qd_r  <= dm_r;
        rmn_r <= '0;
        rmd_r <= '0;
        cnt_r <= '0;
      end
      fr_pkg::OP_DIV: begin
        rmn_r <= dstep_n[2*W-1:W];
        qn_r  <= dstep_n[W-1:0];
        rmd_r <= dstep_d[2*W-1:W];
        qd_r  <= dstep_d[W-1:0];
        cnt_r <= cnt_r + KW'(1);
      end
      fr_pkg::OP_ZERO: begin
        qn_r <= '0;
        qd_r <= ONE_W;
      end
      fr_pkg::OP_OUT: begin
        out_numer_r <= res_neg ? (~sat_n + ONE_W) : sat_n;
        out_denom_r <= qd_r[W-1] ? LIMIT[W-2:0] : qd_r[W-2:0];
      end
      default: begin
      end
    endcase
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_i.op == fr_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign numer_out = out_numer_r;
  assign denom_out = out_denom_r;

endmodule

`default_nettype wire

@@ rtl/core/fraction_reducer_top.sv @@
// Flow: a zero numerator goes from acceptance through the check, zero and output
//   steps; otherwise the result waits on the binary GCD loop plus DATA_WIDTH
//   division steps.
// Throughput: one word at a time; the next is taken only after the result enters
//   the output register and the finish step returns the sequencer to idle.
//   Reset (rst_n low, synchronous) idles the sequencer and empties the output register.
// ----------------------------------------------------------------------------
// fraction_reducer_top
// Reduces a signed fraction to lowest terms with a non-negative denominator,
// using a microcoded sequencer driving a GCD / division datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reducer_top #(
  parameter int DATA_WIDTH = fr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [DATA_WIDTH-1:0] in_numer_in,
  input  wire logic [DATA_WIDTH-1:0] in_denom_in,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [DATA_WIDTH-1:0] out_numer_out,
  output      logic [DATA_WIDTH-2:0] out_denom_out
);

  fr_pkg::ctrl_t ctrl;
  fr_pkg::stat_t stat;

  // sequencer
  fr_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat_i   (stat),
    .in_stall (in_stall),
    .ctrl_o   (ctrl)
  );

  // datapath
  fr_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_i    (ctrl),
    .numer_in  (in_numer_in),
    .denom_in  (in_denom_in),
    .out_stall (out_stall),
    .stat_o    (stat),
    .out_valid (out_valid),
    .numer_out (out_numer_out),
    .denom_out (out_denom_out)
  );

endmodule

`default_nettype wire

@@ rtl/core/fr_chk.sv @@
// ----------------------------------------------------------------------------
// fr_chk
// Port-level checks on the fraction reducer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fr_chk #(
  parameter int DATA_WIDTH = fr_pkg::DATA_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [DATA_WIDTH-1:0] out_numer_out,
  input wire logic [DATA_WIDTH-2:0] out_denom_out
);

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_1  = {DATA_WIDTH{1'b1}};

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_numer_out) && $stable(out_denom_out))
    else $error("result word changed while stalled");

  // busy straight after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  // zero numerator always reads 0/1
  a_zero_numer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_numer_out == '0) |-> (out_denom_out == (DATA_WIDTH-1)'(1)))
    else $error("zero numerator without unit denominator");

  // zero denominator only with unit numerator
  a_zero_denom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_denom_out == '0) |->
      (out_numer_out == DATA_WIDTH'(1)) || (out_numer_out == MINUS_1))
    else $error("zero denominator with non-unit numerator");

  // saturated result never shows the most negative value
  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_numer_out != MOST_NEG))
    else $error("numerator at most negative value");

endmodule

bind fraction_reducer_top fr_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_fr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_numer_out (out_numer_out),
  .out_denom_out (out_denom_out)
);

`default_nettype wire
